FILE: rtl/tkpc_pkg.sv
// tkpc_pkg: types and codes shared by the touch key press classifier modules
// no dependencies
`timescale 1ns / 1ps

package tkpc_pkg;

   localparam int DEB_W  = 4;
   localparam int HOLD_W = 12;
   localparam int CNT_W  = 8;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 12;
   localparam int REQ_DATA_W  = 8;
   localparam int RSP_DATA_W  = 8;

   localparam logic [HOLD_W-1:0] HOLD_MAX = {HOLD_W{1'b1}};
   localparam logic [CNT_W-1:0]  CNT_MAX  = {CNT_W{1'b1}};

   // register indexes on the csr write channel
   localparam logic [CSR_INDEX_W-1:0] REG_DEBOUNCE     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_LONG         = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_LONG_RELEASE = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_DOUBLE_WIN   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_SHORT_SPLIT  = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_REL_FAST     = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_REL_SLOW     = 3'd6;

   typedef enum logic [1:0] {
      PH_IDLE    = 2'd0,
      PH_PRESSED = 2'd1,
      PH_LONG    = 2'd2,
      PH_WAIT    = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      EV_NONE   = 2'd0,
      EV_SHORT  = 2'd1,
      EV_DOUBLE = 2'd2,
      EV_RSVD   = 2'd3
   } press_event_type;

   typedef enum logic [1:0] {
      DIM_NONE = 2'd0,
      DIM_UP   = 2'd1,
      DIM_DOWN = 2'd2,
      DIM_RSVD = 2'd3
   } dim_request_type;

   typedef struct packed {
      logic [DEB_W-1:0]  debounce_frames;
      logic [HOLD_W-1:0] long_frames;
      logic [CNT_W-1:0]  long_release_frames;
      logic [CNT_W-1:0]  double_window_frames;
      logic [HOLD_W-1:0] short_split_frames;
      logic [CNT_W-1:0]  release_fast_frames;
      logic [CNT_W-1:0]  release_slow_frames;
   } cfg_type;

   typedef struct packed {
      logic dim_allowed;
      logic level_at_max;
      logic level_at_min;
   } lamp_type;

   typedef struct packed {
      logic            key_down;
      logic            direction_up;
      logic            long_started;
      dim_request_type dim_request;
      press_event_type press_event;
   } result_type;

endpackage

FILE: rtl/tkpc_debounce.sv
// tkpc_debounce: raw key level debouncer, advanced once per accepted item
// depends on tkpc_pkg
`timescale 1ns / 1ps

module tkpc_debounce import tkpc_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  logic             raw_level,
   input  logic [DEB_W-1:0] debounce_frames,
   output logic             key_next
);

   logic             last_raw_ff, last_raw_in;
   logic [DEB_W-1:0] count_ff, count_in;
   logic             level_ff, level_in;
   logic [DEB_W-1:0] need;

   always_comb begin
      // zero debounce acts as one frame
      need        = (debounce_frames == '0) ? DEB_W'(1) : debounce_frames;
      last_raw_in = last_raw_ff;
      count_in    = count_ff;
      level_in    = level_ff;
      if (raw_level != last_raw_ff) begin
         last_raw_in = raw_level;
         count_in    = '0;
      end else if (count_ff < need) begin
         count_in = count_ff + DEB_W'(1);
         if (count_in >= need) begin
            level_in = raw_level;
         end
      end
   end

   assign key_next = level_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         last_raw_ff <= 1'b0;
         count_ff    <= '0;
         level_ff    <= 1'b0;
      end else if (advance) begin
         last_raw_ff <= last_raw_in;
         count_ff    <= count_in;
         level_ff    <= level_in;
      end
   end

endmodule

FILE: rtl/tkpc_classify.sv
// tkpc_classify: press classification state machine and dimming control
// depends on tkpc_pkg; takes the debounced level from tkpc_debounce
`timescale 1ns / 1ps

module tkpc_classify import tkpc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       advance,
   input  logic       key,
   input  lamp_type   lamp,
   input  cfg_type    cfg,
   output result_type result
);

   phase_type         phase_ff, phase_in;
   logic [HOLD_W-1:0] hold_ff, hold_in;
   logic [CNT_W-1:0]  release_ff, release_in;
   logic [CNT_W-1:0]  window_ff, window_in;
   logic              second_ff, second_in;
   logic              blocked_ff, blocked_in;
   logic              dir_up_ff, dir_up_in;
   logic              limit_ff, limit_in;
   logic              seen_ff, seen_in;
   logic [CNT_W-1:0]  rel_target;
   logic              dir_flip;

   always_comb begin
      phase_in   = phase_ff;
      hold_in    = hold_ff;
      release_in = release_ff;
      window_in  = window_ff;
      second_in  = second_ff;
      blocked_in = blocked_ff;
      dir_up_in  = dir_up_ff;
      limit_in   = limit_ff;
      seen_in    = seen_ff;
      dir_flip   = seen_ff ? ~dir_up_ff : dir_up_ff;
      rel_target = (hold_ff < cfg.short_split_frames) ? cfg.release_fast_frames
                                                      : cfg.release_slow_frames;
      result.press_event  = EV_NONE;
      result.dim_request  = DIM_NONE;
      result.long_started = 1'b0;

      unique case (phase_ff)
         PH_IDLE: begin
            if (key) begin
               phase_in = PH_PRESSED;
               hold_in  = HOLD_W'(1);
            end
         end
         PH_PRESSED: begin
            if (key) begin
               release_in = '0;
               hold_in    = (hold_ff < HOLD_MAX) ? hold_ff + HOLD_W'(1) : HOLD_MAX;
               if (hold_in >= cfg.long_frames && !blocked_ff) begin
                  if (lamp.dim_allowed) begin
                     second_in = 1'b0;
                     phase_in  = PH_LONG;
                     seen_in   = 1'b1;
                     limit_in  = 1'b0;
                     // reverse when already at the limit of the new direction
                     if (dir_flip && lamp.level_at_max) begin
                        dir_up_in = 1'b0;
                     end else if (!dir_flip && lamp.level_at_min) begin
                        dir_up_in = 1'b1;
                     end else begin
                        dir_up_in = dir_flip;
                     end
                     result.long_started = 1'b1;
                  end else begin
                     blocked_in = 1'b1;
                  end
               end
            end else begin
               release_in = (release_ff < CNT_MAX) ? release_ff + CNT_W'(1) : CNT_MAX;
               if (release_in >= rel_target) begin
                  release_in = '0;
                  blocked_in = 1'b0;
                  if (second_ff) begin
                     second_in = 1'b0;
                     phase_in  = PH_IDLE;
                  end else if (hold_ff < cfg.long_frames) begin
                     phase_in  = PH_WAIT;
                     window_in = '0;
                  end else begin
                     phase_in = PH_IDLE;
                  end
               end
            end
         end
         PH_WAIT: begin
            window_in = (window_ff < CNT_MAX) ? window_ff + CNT_W'(1) : CNT_MAX;
            if (key) begin
               second_in          = 1'b1;
               phase_in           = PH_PRESSED;
               hold_in            = HOLD_W'(1);
               result.press_event = EV_DOUBLE;
            end else if (window_in >= cfg.double_window_frames) begin
               phase_in           = PH_IDLE;
               result.press_event = EV_SHORT;
            end
         end
         PH_LONG: begin
            if (key) begin
               release_in = '0;
               if (!limit_ff) begin
                  result.dim_request = dir_up_ff ? DIM_UP : DIM_DOWN;
                  // a step at the limit is taken to fail
                  if (dir_up_ff ? lamp.level_at_max : lamp.level_at_min) begin
                     limit_in = 1'b1;
                  end
               end
            end else begin
               release_in = (release_ff < CNT_MAX) ? release_ff + CNT_W'(1) : CNT_MAX;
               if (release_in >= cfg.long_release_frames) begin
                  release_in = '0;
                  phase_in   = PH_IDLE;
               end
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase

      result.direction_up = dir_up_in;
      result.key_down     = key;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         hold_ff    <= '0;
         release_ff <= '0;
         window_ff  <= '0;
         second_ff  <= 1'b0;
         blocked_ff <= 1'b0;
         dir_up_ff  <= 1'b1;
         limit_ff   <= 1'b0;
         seen_ff    <= 1'b0;
      end else if (advance) begin
         phase_ff   <= phase_in;
         hold_ff    <= hold_in;
         release_ff <= release_in;
         window_ff  <= window_in;
         second_ff  <= second_in;
         blocked_ff <= blocked_in;
         dir_up_ff  <= dir_up_in;
         limit_ff   <= limit_in;
         seen_ff    <= seen_in;
      end
   end

endmodule

FILE: rtl/touch_key_press_classifier.sv
// touch_key_press_classifier: top level, csr registers, result register
// depends on tkpc_pkg, tkpc_debounce, tkpc_classify
//
//   channel  direction  handshake                 payload
//   req      in         req_tvalid / req_tready   req_tdata  (lamp status, raw key)
//   rsp      out        rsp_tvalid / rsp_tready   rsp_tdata  (events, dim step)
//   csr      in         csr_valid / csr_ready     csr_index, csr_data
//
// one item per cycle while rsp does not stall: each item passes the debouncer and
// the classifier combinationally and lands in the result register. req_tready is
// high whenever that register is empty or is being taken, so a stalled rsp side
// stalls req. csr_ready is always high. reset (synchronous) returns all
// registers to their documented defaults and empties the result register.
`timescale 1ns / 1ps

module touch_key_press_classifier import tkpc_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // [0] raw_level, [1] dim_allowed, [2] level_at_max, [3] level_at_min
   input  logic [REQ_DATA_W-1:0]  req_tdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // [1:0] press_event, [3:2] dim_request, [4] long_started,
   // [5] direction_up, [6] key_down
   output logic [RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   cfg_type    cfg_ff;
   result_type result;
   result_type rsp_data_ff;
   logic       rsp_valid_ff;
   logic       advance;
   logic       key_next;
   lamp_type   lamp;

   assign csr_ready  = 1'b1;
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign advance    = req_tvalid && req_tready;

   assign lamp.dim_allowed  = req_tdata[1];
   assign lamp.level_at_max = req_tdata[2];
   assign lamp.level_at_min = req_tdata[3];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_frames      <= DEB_W'(2);
         cfg_ff.long_frames          <= HOLD_W'(25);
         cfg_ff.long_release_frames  <= CNT_W'(5);
         cfg_ff.double_window_frames <= CNT_W'(7);
         cfg_ff.short_split_frames   <= HOLD_W'(12);
         cfg_ff.release_fast_frames  <= CNT_W'(3);
         cfg_ff.release_slow_frames  <= CNT_W'(8);
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_DEBOUNCE:     cfg_ff.debounce_frames      <= csr_data[DEB_W-1:0];
            REG_LONG:         cfg_ff.long_frames          <= csr_data[HOLD_W-1:0];
            REG_LONG_RELEASE: cfg_ff.long_release_frames  <= csr_data[CNT_W-1:0];
            REG_DOUBLE_WIN:   cfg_ff.double_window_frames <= csr_data[CNT_W-1:0];
            REG_SHORT_SPLIT:  cfg_ff.short_split_frames   <= csr_data[HOLD_W-1:0];
            REG_REL_FAST:     cfg_ff.release_fast_frames  <= csr_data[CNT_W-1:0];
            REG_REL_SLOW:     cfg_ff.release_slow_frames  <= csr_data[CNT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   tkpc_debounce u_debounce (
      .clock           (clock),
      .reset           (reset),
      .advance         (advance),
      .raw_level       (req_tdata[0]),
      .debounce_frames (cfg_ff.debounce_frames),
      .key_next        (key_next)
   );

   tkpc_classify u_classify (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .key     (key_next),
      .lamp    (lamp),
      .cfg     (cfg_ff),
      .result  (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_data_ff};

   // an accepted item always leaves a result behind
   a_accept_gives_result: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> rsp_tvalid)
      else $error("accepted item left no result");

   // a long press only starts with the key down
   a_long_needs_key: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_data_ff.long_started |-> rsp_data_ff.key_down)
      else $error("long press started with key up");

   // dim steps are only issued while held
   a_dim_needs_key: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_data_ff.dim_request != DIM_NONE |-> rsp_data_ff.key_down)
      else $error("dim step with key up");

   // double press comes on a press, short press on the window expiry
   a_event_key: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_data_ff.press_event != EV_DOUBLE || rsp_data_ff.key_down) &&
                     (rsp_data_ff.press_event != EV_SHORT || !rsp_data_ff.key_down))
      else $error("press event inconsistent with key level");

endmodule
